FILE: rtl/core/sequential_list_table_engine_core_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the sequential list table engine.
// ---------------------------------------------------------------------------
`ifndef SEQUENTIAL_LIST_TABLE_ENGINE_CORE_DEFINES_SVH
`define SEQUENTIAL_LIST_TABLE_ENGINE_CORE_DEFINES_SVH

`ifndef SYNTH

`define SLTE_ASSERT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("slte assertion failed");

`define SLTE_ASSERT_NEXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("slte assertion failed");

`else

`define SLTE_ASSERT(lbl, ck, rs, ante, cons)

`define SLTE_ASSERT_NEXT(lbl, ck, rs, ante, cons)

`endif

`endif

FILE: rtl/core/slte_pkg.sv
// ---------------------------------------------------------------------------
// slte_pkg
// Shared types and constants of the sequential list table engine.
// ---------------------------------------------------------------------------
`default_nettype none

package slte_pkg;

  localparam int CAPACITY_DEF   = 16;
  localparam int DATA_WIDTH_DEF = 32;

  localparam int REQ_W  = 3;
  localparam int POS_W  = 5;
  localparam int VAL_W  = 32;
  localparam int LCNT_W = 5;

  typedef enum logic [REQ_W-1:0] {
    REQ_INSERT = 3'd0,
    REQ_DELETE = 3'd1,
    REQ_GET    = 3'd2,
    REQ_LOCATE = 3'd3,
    REQ_DELMIN = 3'd4,
    REQ_RANGE  = 3'd5
  } req_t;

  typedef enum logic [2:0] {
    OP_HOLD,
    OP_INSERT,
    OP_MARK_POS,
    OP_MARK_RANGE,
    OP_COMPACT,
    OP_REPLACE
  } cell_op_t;

endpackage

`default_nettype wire

FILE: rtl/core/sequential_list_table_engine_core.sv
// Insert, get, failed requests and unknown requests go from the execute state straight
// to the done state. Delete at a valid position and range delete pass through the compact
// state, which removes the marked elements one at a time. Locate, and delete minimum on a
// non-empty list, run the scan along the whole row before the done state.
// The next request is taken only once the result of the previous one is in the output
// register. Reset clears the element count, the removal marks and the handshake state;
// the cell values are not cleared.
// ---------------------------------------------------------------------------
// sequential_list_table_engine_core
// Ordered list of signed words held in a row of cells that shift in parallel,
// serving insert, delete, get, locate, delete-minimum and range delete.
// ---------------------------------------------------------------------------
`default_nettype none

`include "sequential_list_table_engine_core_defines.svh"

module sequential_list_table_engine_core #(
  parameter int CAPACITY   = slte_pkg::CAPACITY_DEF,
  parameter int DATA_WIDTH = slte_pkg::DATA_WIDTH_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [slte_pkg::REQ_W-1:0]        req_type,
  input  wire logic [slte_pkg::POS_W-1:0]        position,
  input  wire logic signed [slte_pkg::VAL_W-1:0] item_value,
  input  wire logic signed [slte_pkg::VAL_W-1:0] bound_low,
  input  wire logic signed [slte_pkg::VAL_W-1:0] bound_high,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic                                   ok,
  output logic signed [slte_pkg::VAL_W-1:0]      result_value,
  output logic [slte_pkg::POS_W-1:0]             found_position,
  output logic [slte_pkg::LCNT_W-1:0]            list_count
);
  import slte_pkg::*;

  localparam int DW    = DATA_WIDTH;
  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);

  cell_op_t          op;
  logic [IDX_W-1:0]  tgt;
  logic [DW-1:0]     data;
  logic [DW-1:0]     lo;
  logic [DW-1:0]     hi;
  logic [CNT_W-1:0]  cnt;
  logic              any_mark;
  logic [DW-1:0]     rd_or;

  logic [DW-1:0]     val_a   [CAPACITY];
  logic              mark_a  [CAPACITY];
  logic [DW-1:0]     rd_a    [CAPACITY];
  logic              carry_a [CAPACITY];
  logic [DW-1:0]     left_a  [CAPACITY];
  logic [DW-1:0]     right_a [CAPACITY];
  logic              rmark_a [CAPACITY];
  logic              cin_a   [CAPACITY];

  logic              fnd_c  [CAPACITY+1];
  logic [IDX_W-1:0]  fidx_c [CAPACITY+1];
  logic              bvld_c [CAPACITY+1];
  logic [DW-1:0]     bval_c [CAPACITY+1];
  logic [IDX_W-1:0]  bidx_c [CAPACITY+1];
  logic [DW-1:0]     last_c [CAPACITY+1];

  assign fnd_c[0]  = 1'b0;
  assign fidx_c[0] = '0;
  assign bvld_c[0] = 1'b0;
  assign bval_c[0] = '0;
  assign bidx_c[0] = '0;
  assign last_c[0] = '0;

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    if (g == 0) begin : g_first
      assign left_a[g] = '0;
      assign cin_a[g]  = 1'b0;
    end else begin : g_inner
      assign left_a[g] = val_a[g-1];
      assign cin_a[g]  = carry_a[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign right_a[g] = '0;
      assign rmark_a[g] = 1'b0;
    end else begin : g_body
      assign right_a[g] = val_a[g+1];
      assign rmark_a[g] = mark_a[g+1];
    end

    slte_cell #(
      .IDX   (g),
      .IDX_W (IDX_W),
      .CNT_W (CNT_W),
      .DW    (DW)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .op         (op),
      .tgt        (tgt),
      .cnt        (cnt),
      .data       (data),
      .lo         (lo),
      .hi         (hi),
      .val_left   (left_a[g]),
      .val_right  (right_a[g]),
      .mark_right (rmark_a[g]),
      .carry_left (cin_a[g]),
      .carry      (carry_a[g]),
      .val        (val_a[g]),
      .mark       (mark_a[g]),
      .rd_val     (rd_a[g]),
      .src_found  (fnd_c[g]),
      .src_fidx   (fidx_c[g]),
      .src_bvld   (bvld_c[g]),
      .src_bval   (bval_c[g]),
      .src_bidx   (bidx_c[g]),
      .src_last   (last_c[g]),
      .fwd_found  (fnd_c[g+1]),
      .fwd_fidx   (fidx_c[g+1]),
      .fwd_bvld   (bvld_c[g+1]),
      .fwd_bval   (bval_c[g+1]),
      .fwd_bidx   (bidx_c[g+1]),
      .fwd_last   (last_c[g+1])
    );
  end

  always_comb begin
    any_mark = 1'b0;
    rd_or    = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      any_mark = any_mark | mark_a[i];
      rd_or    = rd_or | rd_a[i];
    end
  end

  slte_ctrl #(
    .CAPACITY (CAPACITY),
    .DW       (DW),
    .IDX_W    (IDX_W),
    .CNT_W    (CNT_W)
  ) u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .req_type       (req_type),
    .position       (position),
    .item_value     (item_value),
    .bound_low      (bound_low),
    .bound_high     (bound_high),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .ok             (ok),
    .result_value   (result_value),
    .found_position (found_position),
    .list_count     (list_count),
    .op             (op),
    .tgt            (tgt),
    .data           (data),
    .lo             (lo),
    .hi             (hi),
    .cnt            (cnt),
    .any_mark       (any_mark),
    .rd_val         (rd_or),
    .tok_found      (fnd_c[CAPACITY]),
    .tok_fidx       (fidx_c[CAPACITY]),
    .tok_bval       (bval_c[CAPACITY]),
    .tok_bidx       (bidx_c[CAPACITY]),
    .tok_last       (last_c[CAPACITY])
  );

  `SLTE_ASSERT(cnt_bound_a, clk, rst, 1'b1, cnt <= CNT_W'(CAPACITY))
  `SLTE_ASSERT_NEXT(accept_busy_a, clk, rst, in_valid && !in_stall, in_stall)
  `SLTE_ASSERT_NEXT(accept_cnt_a, clk, rst, in_valid && !in_stall, $stable(cnt))
  `SLTE_ASSERT(mark_busy_a, clk, rst, any_mark, in_stall)

endmodule

`default_nettype wire

FILE: rtl/core/slte_cell.sv
// ---------------------------------------------------------------------------
// slte_cell
// One list element: shifts with its neighbours, carries a removal mark and
// takes part in the scan that travels along the row.
// ---------------------------------------------------------------------------
`default_nettype none

module slte_cell #(
  parameter int IDX   = 0,
  parameter int IDX_W = 4,
  parameter int CNT_W = 5,
  parameter int DW    = 32
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire slte_pkg::cell_op_t  op,
  input  wire logic [IDX_W-1:0]    tgt,
  input  wire logic [CNT_W-1:0]    cnt,
  input  wire logic [DW-1:0]       data,
  input  wire logic [DW-1:0]       lo,
  input  wire logic [DW-1:0]       hi,
  input  wire logic [DW-1:0]       val_left,
  input  wire logic [DW-1:0]       val_right,
  input  wire logic                mark_right,
  input  wire logic                carry_left,
  output logic                     carry,
  output logic [DW-1:0]            val,
  output logic                     mark,
  output logic [DW-1:0]            rd_val,
  input  wire logic                src_found,
  input  wire logic [IDX_W-1:0]    src_fidx,
  input  wire logic                src_bvld,
  input  wire logic [DW-1:0]       src_bval,
  input  wire logic [IDX_W-1:0]    src_bidx,
  input  wire logic [DW-1:0]       src_last,
  output logic                     fwd_found,
  output logic [IDX_W-1:0]         fwd_fidx,
  output logic                     fwd_bvld,
  output logic [DW-1:0]            fwd_bval,
  output logic [IDX_W-1:0]         fwd_bidx,
  output logic [DW-1:0]            fwd_last
);
  import slte_pkg::*;

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

  logic in_list;
  logic at_tgt;
  logic above_tgt;
  logic in_range;
  logic better;
  logic hit;

  assign in_list   = CNT_W'(IDX) < cnt;
  assign at_tgt    = MY_IDX == tgt;
  assign above_tgt = MY_IDX > tgt;
  assign in_range  = ($signed(val) >= $signed(lo)) && ($signed(val) <= $signed(hi));
  assign carry     = carry_left | mark;
  assign rd_val    = at_tgt ? val : '0;
  assign better    = in_list && (!src_bvld || ($signed(val) < $signed(src_bval)));
  assign hit       = in_list && !src_found && (val == data);

  always_ff @(posedge clk) begin
    case (op)
      OP_INSERT: begin
        if (above_tgt) begin
          val <= val_left;
        end else if (at_tgt) begin
          val <= data;
        end
      end
      OP_COMPACT: begin
        if (carry) begin
          val <= val_right;
        end
      end
      OP_REPLACE: begin
        if (at_tgt) begin
          val <= data;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mark <= 1'b0;
    end else begin
      case (op)
        OP_MARK_POS:   mark <= at_tgt;
        OP_MARK_RANGE: mark <= in_list && in_range;
        OP_COMPACT: begin
          if (carry) begin
            mark <= mark_right;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    fwd_found <= src_found | hit;
    fwd_fidx  <= hit ? MY_IDX : src_fidx;
    fwd_bvld  <= src_bvld | in_list;
    fwd_bval  <= better ? val : src_bval;
    fwd_bidx  <= better ? MY_IDX : src_bidx;
    fwd_last  <= in_list ? val : src_last;
  end

endmodule

`default_nettype wire

FILE: rtl/core/slte_ctrl.sv
// ---------------------------------------------------------------------------
// slte_ctrl
// Request sequencer: checks positions, drives the cell row and holds the
// element count and the result register.
// ---------------------------------------------------------------------------
`default_nettype none

module slte_ctrl #(
  parameter int CAPACITY = 16,
  parameter int DW       = 32,
  parameter int IDX_W    = 4,
  parameter int CNT_W    = 5
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [slte_pkg::REQ_W-1:0]        req_type,
  input  wire logic [slte_pkg::POS_W-1:0]        position,
  input  wire logic signed [slte_pkg::VAL_W-1:0] item_value,
  input  wire logic signed [slte_pkg::VAL_W-1:0] bound_low,
  input  wire logic signed [slte_pkg::VAL_W-1:0] bound_high,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic                                   ok,
  output logic signed [slte_pkg::VAL_W-1:0]      result_value,
  output logic [slte_pkg::POS_W-1:0]             found_position,
  output logic [slte_pkg::LCNT_W-1:0]            list_count,
  output slte_pkg::cell_op_t                     op,
  output logic [IDX_W-1:0]                       tgt,
  output logic [DW-1:0]                          data,
  output logic [DW-1:0]                          lo,
  output logic [DW-1:0]                          hi,
  output logic [CNT_W-1:0]                       cnt,
  input  wire logic                              any_mark,
  input  wire logic [DW-1:0]                     rd_val,
  input  wire logic                              tok_found,
  input  wire logic [IDX_W-1:0]                  tok_fidx,
  input  wire logic [DW-1:0]                     tok_bval,
  input  wire logic [IDX_W-1:0]                  tok_bidx,
  input  wire logic [DW-1:0]                     tok_last
);
  import slte_pkg::*;

  localparam int XV = DW + VAL_W;
  localparam int XC = CNT_W + POS_W + 1;
  localparam int XT = IDX_W + POS_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_COMPACT,
    S_SCAN,
    S_DONE
  } state_t;

  state_t            state;
  req_t              req_q;
  logic [POS_W-1:0]  pos_q;
  logic [DW-1:0]     item_q;
  logic [IDX_W-1:0]  scan_cnt;
  logic              res_ok;
  logic [DW-1:0]     res_val;
  logic [CNT_W-1:0]  res_fpos;

  logic signed [XV-1:0] item_w;
  logic signed [XV-1:0] low_w;
  logic signed [XV-1:0] high_w;
  logic signed [XV-1:0] res_w;
  logic [XC-1:0]        pos_x;
  logic [XC-1:0]        cnt_x;
  logic [POS_W-1:0]     pos_m1;
  logic [XT-1:0]        pos_wide;
  logic [IDX_W-1:0]     pos_tgt;
  logic                 pos_ok;
  logic                 ins_ok;
  logic                 scan_last;

  assign item_w   = XV'(item_value);
  assign low_w    = XV'(bound_low);
  assign high_w   = XV'(bound_high);
  assign res_w    = XV'($signed(res_val));

  assign pos_x    = XC'(pos_q);
  assign cnt_x    = XC'(cnt);
  assign pos_m1   = pos_q - POS_W'(1);
  assign pos_wide = XT'(pos_m1);
  assign pos_tgt  = pos_wide[IDX_W-1:0];
  assign pos_ok   = (pos_x != '0) && (pos_x <= cnt_x);
  assign ins_ok   = (pos_x != '0) && (pos_x <= cnt_x + XC'(1)) && (cnt != CNT_W'(CAPACITY));

  assign scan_last = scan_cnt == IDX_W'(CAPACITY - 1);
  assign in_stall  = state != S_IDLE;

  always_comb begin
    op   = OP_HOLD;
    tgt  = pos_tgt;
    data = item_q;
    case (state)
      S_EXEC: begin
        case (req_q)
          REQ_INSERT: if (ins_ok) op = OP_INSERT;
          REQ_DELETE: if (pos_ok) op = OP_MARK_POS;
          REQ_RANGE:  op = OP_MARK_RANGE;
          default:    op = OP_HOLD;
        endcase
      end
      S_COMPACT: if (any_mark) op = OP_COMPACT;
      S_SCAN: begin
        if (scan_last && (req_q == REQ_DELMIN)) begin
          op   = OP_REPLACE;
          tgt  = tok_bidx;
          data = tok_last;
        end
      end
      default: op = OP_HOLD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            req_q  <= req_t'(req_type);
            pos_q  <= position;
            item_q <= item_w[DW-1:0];
            lo     <= low_w[DW-1:0];
            hi     <= high_w[DW-1:0];
            state  <= S_EXEC;
          end
        end
        S_EXEC: begin
          res_fpos <= '0;
          scan_cnt <= '0;
          case (req_q)
            REQ_INSERT: begin
              res_ok  <= ins_ok;
              res_val <= '0;
              state   <= S_DONE;
              if (ins_ok) begin
                cnt <= cnt + CNT_W'(1);
              end
            end
            REQ_DELETE: begin
              res_ok  <= pos_ok;
              res_val <= pos_ok ? rd_val : '0;
              state   <= pos_ok ? S_COMPACT : S_DONE;
            end
            REQ_GET: begin
              res_ok  <= pos_ok;
              res_val <= pos_ok ? rd_val : '0;
              state   <= S_DONE;
            end
            REQ_LOCATE: begin
              res_ok  <= 1'b1;
              res_val <= '0;
              state   <= S_SCAN;
            end
            REQ_DELMIN: begin
              res_ok  <= 1'b0;
              res_val <= '0;
              state   <= (cnt != '0) ? S_SCAN : S_DONE;
            end
            REQ_RANGE: begin
              res_ok  <= 1'b1;
              res_val <= '0;
              state   <= S_COMPACT;
            end
            default: begin
              res_ok  <= 1'b0;
              res_val <= '0;
              state   <= S_DONE;
            end
          endcase
        end
        S_COMPACT: begin
          if (any_mark) begin
            cnt <= cnt - CNT_W'(1);
          end else begin
            state <= S_DONE;
          end
        end
        S_SCAN: begin
          scan_cnt <= scan_cnt + IDX_W'(1);
          if (scan_last) begin
            state <= S_DONE;
            if (req_q == REQ_LOCATE) begin
              res_fpos <= tok_found ? CNT_W'(tok_fidx) + CNT_W'(1) : '0;
            end else begin
              res_ok  <= 1'b1;
              res_val <= tok_bval;
              cnt     <= cnt - CNT_W'(1);
            end
          end
        end
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            ok             <= res_ok;
            result_value   <= res_w[VAL_W-1:0];
            found_position <= POS_W'(res_fpos);
            list_count     <= LCNT_W'(cnt);
            out_valid      <= 1'b1;
            state          <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: dv/sequential_list_table_engine_core_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Sequential list table engine checker
// Watches the request and result channels of the list engine, keeps its own
// copy of the stored list, works out the reply to every accepted request and
// compares each result beat, field by field, with the oldest reply waiting.
// ---------------------------------------------------------------------------
module sequential_list_table_engine_core_checker
  import slte_pkg::*;
#(
  parameter int DEPTH = CAPACITY_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  input  logic                     in_stall,
  input  logic [REQ_W-1:0]         req_type,
  input  logic [POS_W-1:0]         position,
  input  logic signed [VAL_W-1:0]  item_value,
  input  logic signed [VAL_W-1:0]  bound_low,
  input  logic signed [VAL_W-1:0]  bound_high,
  input  logic                     out_valid,
  input  logic                     out_stall,
  input  logic                     ok,
  input  logic signed [VAL_W-1:0]  result_value,
  input  logic [POS_W-1:0]         found_position,
  input  logic [LCNT_W-1:0]        list_count,
  output int                       fail_count,
  output int                       outstanding,
  output int                       shadow_len
);

  typedef struct packed {
    logic                    ok;
    logic signed [VAL_W-1:0] value;
    logic [POS_W-1:0]        found;
    logic [LCNT_W-1:0]       count;
  } list_reply_t;

  logic signed [VAL_W-1:0] cells [DEPTH];
  int                      fill = 0;
  list_reply_t             pending_replies [$];
  list_reply_t             want;
  list_reply_t             got;

  initial begin
    fail_count  = 0;
    outstanding = 0;
    shadow_len  = 0;
  end

  function automatic list_reply_t list_apply(input logic [REQ_W-1:0] kind,
                                             input logic [POS_W-1:0] pos,
                                             input logic signed [VAL_W-1:0] val,
                                             input logic signed [VAL_W-1:0] lo,
                                             input logic signed [VAL_W-1:0] hi);
    list_reply_t r;
    int          p;
    int          j;
    int          keep;
    int          best;
    r = '0;
    p = pos;
    case (kind)
      REQ_INSERT: begin
        if (p >= 1 && p <= fill + 1 && fill < DEPTH) begin
          for (j = fill; j >= p; j--) cells[j] = cells[j-1];
          cells[p-1] = val;
          fill++;
          r.ok = 1'b1;
        end
      end
      REQ_DELETE: begin
        if (p >= 1 && p <= fill) begin
          r.value = cells[p-1];
          for (j = p; j < fill; j++) cells[j-1] = cells[j];
          fill--;
          r.ok = 1'b1;
        end
      end
      REQ_GET: begin
        if (p >= 1 && p <= fill) begin
          r.value = cells[p-1];
          r.ok    = 1'b1;
        end
      end
      REQ_LOCATE: begin
        r.ok = 1'b1;
        for (j = 0; j < fill; j++) begin
          if (cells[j] == val) begin
            r.found = POS_W'(j + 1);
            break;
          end
        end
      end
      REQ_DELMIN: begin
        if (fill > 0) begin
          best = 0;
          for (j = 1; j < fill; j++) if (cells[j] < cells[best]) best = j;
          r.value     = cells[best];
          cells[best] = cells[fill-1];
          fill--;
          r.ok = 1'b1;
        end
      end
      REQ_RANGE: begin
        keep = 0;
        for (j = 0; j < fill; j++) begin
          if (!(cells[j] >= lo && cells[j] <= hi)) begin
            cells[keep] = cells[j];
            keep++;
          end
        end
        fill = keep;
        r.ok = 1'b1;
      end
      default: ;
    endcase
    r.count = LCNT_W'(fill);
    return r;
  endfunction

  task automatic compare_field(input string field, input logic signed [VAL_W:0] exp_val,
                               input logic signed [VAL_W:0] act_val);
    if (act_val !== exp_val) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, exp_val, act_val);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      fill = 0;
      pending_replies.delete();
    end else begin
      if (out_valid && !out_stall) begin
        got = '{ok, result_value, found_position, list_count};
        if (pending_replies.size() == 0) begin
          $display("%0t: result beat with no request waiting, actual ok=%0b value=%0d",
                   $time, ok, result_value);
          fail_count++;
        end else begin
          want = pending_replies.pop_front();
          compare_field("ok", {1'b0, want.ok}, {1'b0, got.ok});
          compare_field("result_value", want.value, got.value);
          compare_field("found_position", {1'b0, want.found}, {1'b0, got.found});
          compare_field("list_count", {1'b0, want.count}, {1'b0, got.count});
        end
      end
      if (in_valid && !in_stall) begin
        pending_replies.push_back(list_apply(req_type, position, item_value,
                                             bound_low, bound_high));
      end
    end
    outstanding = pending_replies.size();
    shadow_len  = fill;
  end

endmodule

FILE: dv/sequential_list_table_engine_core_test.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Sequential list table engine testbench
// Drives a short directed run through the edge cases of the list engine and
// then several hundred random requests in filling, draining and mixed phases,
// with random gaps and stalls on both channels. The checker predicts and
// compares; this module makes the stimulus and gives the verdict.
// ---------------------------------------------------------------------------
module sequential_list_table_engine_core_test;
  import slte_pkg::*;

  localparam logic [REQ_W-1:0] REQ_RSVD_A     = 3'd6;
  localparam logic [REQ_W-1:0] REQ_RSVD_B     = 3'd7;
  localparam int               WATCHDOG_LIMIT = 2000;
  localparam int               DRAIN_CYCLES   = 40;
  localparam int               PHASES         = 19;
  localparam int               PHASE_ITEMS    = 50;
  localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7fffffff;
  localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh80000000;

  logic                    clk        = 1'b0;
  logic                    rst        = 1'b1;
  logic                    in_valid   = 1'b0;
  logic                    in_stall;
  logic [REQ_W-1:0]        req_type   = '0;
  logic [POS_W-1:0]        position   = '0;
  logic signed [VAL_W-1:0] item_value = '0;
  logic signed [VAL_W-1:0] bound_low  = '0;
  logic signed [VAL_W-1:0] bound_high = '0;
  logic                    out_valid;
  logic                    out_stall  = 1'b0;
  logic                    ok;
  logic signed [VAL_W-1:0] result_value;
  logic [POS_W-1:0]        found_position;
  logic [LCNT_W-1:0]       list_count;

  int fail_count;
  int outstanding;
  int shadow_len;
  int idle_cycles = 0;
  int stall_left  = 0;
  int stall_draw;
  bit burst       = 1'b0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  sequential_list_table_engine_core DUT (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .req_type      (req_type),
    .position      (position),
    .item_value    (item_value),
    .bound_low     (bound_low),
    .bound_high    (bound_high),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .ok            (ok),
    .result_value  (result_value),
    .found_position(found_position),
    .list_count    (list_count)
  );

  sequential_list_table_engine_core_checker checker_inst (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .req_type      (req_type),
    .position      (position),
    .item_value    (item_value),
    .bound_low     (bound_low),
    .bound_high    (bound_high),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .ok            (ok),
    .result_value  (result_value),
    .found_position(found_position),
    .list_count    (list_count),
    .fail_count    (fail_count),
    .outstanding   (outstanding),
    .shadow_len    (shadow_len)
  );

  // After each beat the receiver draws a fresh random hold-off, which is zero in burst phases.
  always @(posedge clk) begin
    if (rst) begin
      stall_left <= 0;
      out_stall  <= 1'b0;
    end else if (out_valid && !out_stall) begin
      stall_draw = burst ? 0 : $urandom_range(0, 5);
      stall_left <= stall_draw;
      out_stall  <= (stall_draw != 0);
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= (stall_left > 1);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  task automatic issue(input logic [REQ_W-1:0] kind, input int pos,
                       input logic signed [VAL_W-1:0] val,
                       input logic signed [VAL_W-1:0] lo,
                       input logic signed [VAL_W-1:0] hi);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    req_type   <= kind;
    position   <= POS_W'(pos);
    item_value <= val;
    bound_low  <= lo;
    bound_high <= hi;
    do @(posedge clk); while (in_stall);
  endtask

  function automatic logic signed [VAL_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return VAL_W'(int'($urandom_range(0, 8)) - 4);
      4:          return VAL_MAX;
      5:          return VAL_MIN;
      default:    return $urandom;
    endcase
  endfunction

  task automatic random_request(input int mode);
    logic [REQ_W-1:0]        kinds [7];
    int                      weights [7];
    int                      roll;
    int                      idx;
    int                      pos;
    logic signed [VAL_W-1:0] lo;
    logic signed [VAL_W-1:0] hi;
    logic signed [VAL_W-1:0] swap;
    kinds = '{REQ_INSERT, REQ_DELETE, REQ_GET, REQ_LOCATE, REQ_DELMIN, REQ_RANGE, REQ_RSVD_A};
    case (mode)
      0:       weights = '{70, 6, 8, 8, 4, 2, 2};
      1:       weights = '{15, 22, 12, 15, 15, 18, 3};
      default: weights = '{30, 16, 14, 16, 10, 10, 4};
    endcase
    roll = $urandom_range(0, 99);
    idx  = 0;
    while (roll >= weights[idx]) begin
      roll -= weights[idx];
      idx++;
    end
    if (idx == 6 && $urandom_range(0, 1)) kinds[6] = REQ_RSVD_B;
    if ($urandom_range(0, 7) == 0) pos = $urandom_range(0, 31);
    else pos = $urandom_range(0, shadow_len + 2);
    lo = pick_value();
    hi = pick_value();
    case ($urandom_range(0, 3))
      0: hi = lo;
      1: if (lo > hi) begin
        swap = lo;
        lo   = hi;
        hi   = swap;
      end
      default: ;
    endcase
    issue(kinds[idx], pos, pick_value(), lo, hi);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    issue(REQ_DELMIN, 0, 0, 0, 0);
    issue(REQ_DELETE, 1, 0, 0, 0);
    issue(REQ_GET, 0, 0, 0, 0);
    issue(REQ_INSERT, 0, 5, 0, 0);
    issue(REQ_INSERT, 2, 5, 0, 0);
    issue(REQ_INSERT, 1, VAL_MAX, 0, 0);
    issue(REQ_INSERT, 1, VAL_MIN, 0, 0);
    issue(REQ_INSERT, 3, 0, 0, 0);
    issue(REQ_INSERT, 2, -1, 0, 0);
    issue(REQ_INSERT, 31, 9, 0, 0);
    issue(REQ_GET, 4, 0, 0, 0);
    issue(REQ_GET, 5, 0, 0, 0);
    issue(REQ_LOCATE, 0, -1, 0, 0);
    issue(REQ_LOCATE, 0, 12345, 0, 0);
    issue(REQ_DELMIN, 0, 0, 0, 0);
    issue(REQ_INSERT, 4, -1, 0, 0);
    issue(REQ_DELMIN, 0, 0, 0, 0);
    issue(REQ_RANGE, 0, 0, 5, -5);
    issue(REQ_RANGE, 0, 0, 0, 0);
    issue(REQ_RSVD_A, 1, VAL_MAX, VAL_MIN, VAL_MAX);
    issue(REQ_RSVD_B, 31, -1, -1, -1);
    issue(REQ_DELETE, 2, 0, 0, 0);
    issue(REQ_DELETE, 2, 0, 0, 0);
    issue(REQ_RANGE, 0, 0, VAL_MIN, VAL_MAX);

    for (int phase = 0; phase < PHASES; phase++) begin
      burst <= (phase % 4 == 3);
      for (int n = 0; n < PHASE_ITEMS; n++) random_request(phase % 3);
    end
    in_valid <= 1'b0;

    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
